// File: hw/rtl/swtf_pkg.sv
// Shared types and constants for the sliding window traffic feature block.
package swtf_pkg;

	localparam int unsigned START_MAX    = 1048575;
	localparam int unsigned GAP_MAX      = 1073741823;
	localparam int unsigned USEC_PER_SEC = 1000000;
	localparam int unsigned DIV_NW       = 48;
	localparam int unsigned IN_TDATA_W   = 96;
	localparam int unsigned OUT_TDATA_W  = 168;

	localparam logic [1:0] REG_WINDOW_LEN    = 2'd0;
	localparam logic [1:0] REG_WINDOW_STEP   = 2'd1;
	localparam logic [1:0] REG_EXCLUDED_ADDR = 2'd2;

	localparam logic [3:0] FLAG_SYN    = 4'd1;
	localparam logic [3:0] FLAG_SYNACK = 4'd2;
	localparam logic [3:0] FLAG_SYNRST = 4'd3;
	localparam logic [3:0] FLAG_SYNFIN = 4'd4;
	localparam logic [3:0] FLAG_XMAS   = 4'd5;
	localparam logic [3:0] FLAG_FIN    = 4'd6;
	localparam logic [3:0] FLAG_FINACK = 4'd7;
	localparam logic [3:0] FLAG_FINRST = 4'd8;

	typedef enum logic {KIND_RECORD, KIND_FLUSH} kind_t;

	typedef struct packed {
		logic [3:0]  flag_class;
		logic [15:0] pkt_len;
		logic [19:0] time_usec;
		logic [19:0] time_sec;
		logic [31:0] src_addr;
	} rec_t;

	typedef struct packed {
		kind_t kind;
		rec_t  rec;
	} item_t;

	typedef struct packed {
		logic [9:0]  window_len;
		logic [9:0]  window_step;
		logic [31:0] excluded_addr;
	} cfg_t;

	typedef struct packed {
		logic               overflow;
		logic [29:0]        top_avg_gap_usec;
		logic [23:0]        mean_size_q8;
		logic [12:0]        suspicious_count;
		logic signed [13:0] fin_minus_syn;
		logic signed [13:0] syn_minus_synack;
		logic [12:0]        top_count;
		logic [12:0]        packet_count;
		logic [20:0]        window_end_sec;
		logic [19:0]        window_start_sec;
	} report_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CHECK, ST_REP_INIT, ST_P1_RD, ST_P1_TAL, ST_T_RD, ST_T_CMP,
		ST_S_RD, ST_S_CMP, ST_G_RD, ST_G_CMP, ST_G_MUL, ST_G_ADD, ST_G_DIV, ST_G_WAIT,
		ST_M_DIV, ST_M_WAIT, ST_EMIT, ST_DROP_RD, ST_DROP_CHK, ST_SK_DIV, ST_SK_WAIT,
		ST_SK_MUL, ST_SK_SET, ST_APPEND
	} bk_state_t;

endpackage

// File: hw/rtl/swtf_ram.sv
// Generic single write port, single read port RAM with registered read.
module swtf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hw/rtl/swtf_div.sv
// Restoring divider, one quotient bit per cycle.
module swtf_div #(
	parameter int unsigned NW = 48,
	parameter int unsigned DW = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);

	localparam int unsigned CW = $clog2(NW + 1);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [NW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          fits;

	assign trial    = {rem_q, quo_q[NW-1]};
	assign fits     = trial >= {1'b0, dvs_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

endmodule

// File: hw/rtl/swtf_front.sv
// Input side: takes stream transactions, classifies them and queues them for the engine.
module swtf_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [swtf_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic                                s_tuser,
	output logic                                q_valid,
	output swtf_pkg::item_t                     q_item,
	input  logic                                q_pop
);
	import swtf_pkg::*;

	item_t      slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	item_t      item_in;
	logic       push;

	always_comb begin
		item_in.kind            = s_tuser ? KIND_FLUSH : KIND_RECORD;
		item_in.rec.src_addr    = s_tdata[31:0];
		item_in.rec.time_sec    = s_tdata[51:32];
		item_in.rec.time_usec   = s_tdata[71:52];
		item_in.rec.pkt_len     = s_tdata[87:72];
		item_in.rec.flag_class  = s_tdata[91:88];
	end

	assign s_tready = cnt_q != 2'd2;
	assign push     = s_tvalid && s_tready;
	assign q_valid  = cnt_q != 2'd0;
	assign q_item   = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop && q_valid) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop && q_valid);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= item_in;
		end
	end

endmodule

// File: hw/rtl/swtf_back.sv
// Engine: record store, window bookkeeping and report sequencer.
module swtf_back #(
	parameter int unsigned RECORD_DEPTH = 4096,
	parameter int unsigned ADDR_ENTRIES = 64,
	parameter int unsigned MAX_REPORTS  = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  swtf_pkg::cfg_t    cfg,
	input  logic              q_valid,
	input  swtf_pkg::item_t   q_item,
	output logic              q_pop,
	output logic              out_valid,
	output swtf_pkg::report_t out_rep,
	output logic              out_last,
	input  logic              out_ready
);
	import swtf_pkg::*;

	localparam int unsigned AW     = $clog2(RECORD_DEPTH);
	localparam int unsigned CNT_W  = $clog2(RECORD_DEPTH + 1);
	localparam int unsigned SUMW   = CNT_W + 1;
	localparam int unsigned LEN_SW = CNT_W + 16;
	localparam int unsigned TW     = $clog2(ADDR_ENTRIES);
	localparam int unsigned TAB_W  = 32 + CNT_W;
	localparam int unsigned DIV_DW = (CNT_W > 10) ? CNT_W : 10;
	localparam int unsigned REC_W  = $bits(rec_t);

	bk_state_t          state_q, state_d;
	logic [19:0]        start_q, start_d;
	logic [AW-1:0]      head_q, head_d;
	logic [CNT_W-1:0]   fill_q, fill_d;
	logic               drop_q, drop_d;
	logic               out_valid_q, out_valid_d;

	item_t              cur_q, cur_d;
	logic [6:0]         n_q, n_d;
	logic [CNT_W-1:0]   i_q, i_d;
	logic [TW:0]        j_q, j_d;
	logic [TW:0]        naddr_q, naddr_d;
	logic [31:0]        a_q, a_d;
	logic [CNT_W-1:0]   syn_q, syn_d, synack_q, synack_d, fin_q, fin_d, sus_q, sus_d;
	logic [LEN_SW-1:0]  sum_q, sum_d;
	logic               ovf_q, ovf_d;
	logic [31:0]        best_addr_q, best_addr_d;
	logic [CNT_W-1:0]   best_cnt_q, best_cnt_d;
	logic               best_vld_q, best_vld_d;
	logic               seen_q, seen_d;
	logic [19:0]        fsec_q, fsec_d, fusec_q, fusec_d, lsec_q, lsec_d, lusec_q, lusec_d;
	logic [39:0]        fus_q, fus_d, lus_q, lus_d;
	logic [29:0]        gap_q, gap_d;
	logic [23:0]        mean_q, mean_d;
	logic [21:0]        k_q, k_d;
	logic [31:0]        prod_q, prod_d;
	logic               after_skip_q, after_skip_d;
	report_t            out_q, out_d;
	logic               out_last_q, out_last_d;

	logic               rec_we;
	logic [AW-1:0]      rec_waddr, rec_raddr;
	logic [REC_W-1:0]   rec_wdata, rec_rdata;
	rec_t               rd_rec;
	logic               tab_we;
	logic [TW-1:0]      tab_waddr, tab_raddr;
	logic [TAB_W-1:0]   tab_wdata, tab_rdata;
	logic [31:0]        tab_addr;
	logic [CNT_W-1:0]   tab_cnt;
	logic               div_start, div_done;
	logic [DIV_NW-1:0]  div_dividend, div_quo;
	logic [DIV_DW-1:0]  div_divisor;

	logic [9:0]         step_eff;
	logic [20:0]        win_end;
	logic               win_hit;
	logic [SUMW-1:0]    rd_sum, rd_idx, ap_sum, ap_idx;
	logic [20:0]        nxt_start_sum;
	logic [19:0]        nxt_start;
	logic [32:0]        skip_sum;
	logic [AW:0]        head_inc;

	assign rd_rec   = rec_t'(rec_rdata);
	assign tab_addr = tab_rdata[TAB_W-1:CNT_W];
	assign tab_cnt  = tab_rdata[CNT_W-1:0];

	assign step_eff = (cfg.window_step == 10'd0) ? 10'd1 : cfg.window_step;
	assign win_end  = 21'(start_q) + 21'(cfg.window_len);
	assign win_hit  = 21'(cur_q.rec.time_sec) >= win_end;

	assign rd_sum = SUMW'(head_q) + SUMW'(i_q);
	assign rd_idx = (rd_sum >= SUMW'(RECORD_DEPTH)) ? rd_sum - SUMW'(RECORD_DEPTH) : rd_sum;
	assign ap_sum = SUMW'(head_q) + SUMW'(fill_q);
	assign ap_idx = (ap_sum >= SUMW'(RECORD_DEPTH)) ? ap_sum - SUMW'(RECORD_DEPTH) : ap_sum;
	assign head_inc = (AW + 1)'(head_q) + (AW + 1)'(1);

	assign nxt_start_sum = 21'(start_q) + 21'(step_eff);
	assign nxt_start     = (nxt_start_sum > 21'(START_MAX)) ? 20'(START_MAX) : nxt_start_sum[19:0];
	assign skip_sum      = 33'(start_q) + 33'(prod_q);

	assign out_valid = out_valid_q;
	assign out_rep   = out_q;
	assign out_last  = out_last_q;

	swtf_ram #(.WIDTH(REC_W), .DEPTH(RECORD_DEPTH)) u_rec_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (rec_waddr),
		.wdata (rec_wdata),
		.raddr (rec_raddr),
		.rdata (rec_rdata)
	);

	swtf_ram #(.WIDTH(TAB_W), .DEPTH(ADDR_ENTRIES)) u_tab_ram (
		.clk   (clk),
		.we    (tab_we),
		.waddr (tab_waddr),
		.wdata (tab_wdata),
		.raddr (tab_raddr),
		.rdata (tab_rdata)
	);

	swtf_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		state_d      = state_q;
		start_d      = start_q;
		head_d       = head_q;
		fill_d       = fill_q;
		drop_d       = drop_q;
		out_valid_d  = out_valid_q && !out_ready;
		cur_d        = cur_q;
		n_d          = n_q;
		i_d          = i_q;
		j_d          = j_q;
		naddr_d      = naddr_q;
		a_d          = a_q;
		syn_d        = syn_q;
		synack_d     = synack_q;
		fin_d        = fin_q;
		sus_d        = sus_q;
		sum_d        = sum_q;
		ovf_d        = ovf_q;
		best_addr_d  = best_addr_q;
		best_cnt_d   = best_cnt_q;
		best_vld_d   = best_vld_q;
		seen_d       = seen_q;
		fsec_d       = fsec_q;
		fusec_d      = fusec_q;
		lsec_d       = lsec_q;
		lusec_d      = lusec_q;
		fus_d        = fus_q;
		lus_d        = lus_q;
		gap_d        = gap_q;
		mean_d       = mean_q;
		k_d          = k_q;
		prod_d       = prod_q;
		after_skip_d = after_skip_q;
		out_d        = out_q;
		out_last_d   = out_last_q;
		q_pop        = 1'b0;
		rec_we       = 1'b0;
		rec_waddr    = AW'(ap_idx);
		rec_wdata    = cur_q.rec;
		rec_raddr    = AW'(rd_idx);
		tab_we       = 1'b0;
		tab_waddr    = j_q[TW-1:0];
		tab_wdata    = {a_q, CNT_W'(1)};
		tab_raddr    = j_q[TW-1:0];
		div_start    = 1'b0;
		div_dividend = DIV_NW'(cur_q.rec.time_sec - start_q - 20'(cfg.window_len));
		div_divisor  = DIV_DW'(step_eff);

		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					cur_d   = q_item;
					n_d     = 7'd0;
					state_d = (q_item.kind == KIND_FLUSH) ? ST_REP_INIT : ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (win_hit && n_q < 7'(MAX_REPORTS)) begin
					state_d = ST_REP_INIT;
				end else if (win_hit) begin
					state_d = ST_SK_DIV;
				end else begin
					state_d = ST_APPEND;
				end
			end
			ST_REP_INIT: begin
				i_d        = '0;
				naddr_d    = '0;
				syn_d      = '0;
				synack_d   = '0;
				fin_d      = '0;
				sus_d      = '0;
				sum_d      = '0;
				ovf_d      = drop_q;
				best_cnt_d = '0;
				best_vld_d = 1'b0;
				gap_d      = '0;
				state_d    = ST_P1_RD;
			end
			// first pass: tallies and per-address counts
			ST_P1_RD: begin
				if (i_q == fill_q) begin
					j_d     = '0;
					state_d = ST_S_RD;
				end else begin
					state_d = ST_P1_TAL;
				end
			end
			ST_P1_TAL: begin
				a_d = rd_rec.src_addr;
				if (rd_rec.flag_class == FLAG_SYN) syn_d = syn_q + 1'b1;
				if (rd_rec.flag_class == FLAG_SYNACK) synack_d = synack_q + 1'b1;
				if (rd_rec.flag_class == FLAG_FIN || rd_rec.flag_class == FLAG_FINACK) begin
					fin_d = fin_q + 1'b1;
				end
				if (rd_rec.flag_class == FLAG_SYNRST || rd_rec.flag_class == FLAG_SYNFIN ||
				    rd_rec.flag_class == FLAG_XMAS || rd_rec.flag_class == FLAG_FINRST) begin
					sus_d = sus_q + 1'b1;
				end
				sum_d   = sum_q + LEN_SW'(rd_rec.pkt_len);
				j_d     = '0;
				state_d = ST_T_RD;
			end
			ST_T_RD: begin
				if (j_q == naddr_q) begin
					if (naddr_q < (TW + 1)'(ADDR_ENTRIES)) begin
						tab_we    = 1'b1;
						tab_waddr = naddr_q[TW-1:0];
						naddr_d   = naddr_q + 1'b1;
					end else begin
						ovf_d = 1'b1;
					end
					i_d     = i_q + 1'b1;
					state_d = ST_P1_RD;
				end else begin
					state_d = ST_T_CMP;
				end
			end
			ST_T_CMP: begin
				if (tab_addr == a_q) begin
					tab_we    = 1'b1;
					tab_wdata = {a_q, tab_cnt + 1'b1};
					i_d       = i_q + 1'b1;
					state_d   = ST_P1_RD;
				end else begin
					j_d     = j_q + 1'b1;
					state_d = ST_T_RD;
				end
			end
			// pick the most active address other than the excluded one, earliest entry wins ties
			ST_S_RD: begin
				if (j_q == naddr_q) begin
					i_d     = '0;
					seen_d  = 1'b0;
					state_d = best_vld_q ? ST_G_RD : ST_M_DIV;
				end else begin
					state_d = ST_S_CMP;
				end
			end
			ST_S_CMP: begin
				if (tab_addr != cfg.excluded_addr && tab_cnt > best_cnt_q) begin
					best_addr_d = tab_addr;
					best_cnt_d  = tab_cnt;
					best_vld_d  = 1'b1;
				end
				j_d     = j_q + 1'b1;
				state_d = ST_S_RD;
			end
			// second pass: first and last time of the top address
			ST_G_RD: begin
				state_d = (i_q == fill_q) ? ST_G_MUL : ST_G_CMP;
			end
			ST_G_CMP: begin
				if (rd_rec.src_addr == best_addr_q) begin
					if (!seen_q) begin
						fsec_d  = rd_rec.time_sec;
						fusec_d = rd_rec.time_usec;
					end
					lsec_d  = rd_rec.time_sec;
					lusec_d = rd_rec.time_usec;
					seen_d  = 1'b1;
				end
				i_d     = i_q + 1'b1;
				state_d = ST_G_RD;
			end
			ST_G_MUL: begin
				fus_d   = 40'(fsec_q) * 40'(USEC_PER_SEC);
				lus_d   = 40'(lsec_q) * 40'(USEC_PER_SEC);
				state_d = ST_G_ADD;
			end
			ST_G_ADD: begin
				fus_d   = fus_q + 40'(fusec_q);
				lus_d   = lus_q + 40'(lusec_q);
				state_d = ST_G_DIV;
			end
			ST_G_DIV: begin
				div_start    = 1'b1;
				div_dividend = (lus_q > fus_q) ? DIV_NW'(lus_q - fus_q) : '0;
				div_divisor  = DIV_DW'(best_cnt_q);
				state_d      = ST_G_WAIT;
			end
			ST_G_WAIT: begin
				if (div_done) begin
					gap_d   = (div_quo > DIV_NW'(GAP_MAX)) ? 30'(GAP_MAX) : div_quo[29:0];
					state_d = ST_M_DIV;
				end
			end
			ST_M_DIV: begin
				if (fill_q == '0) begin
					mean_d  = '0;
					state_d = ST_EMIT;
				end else begin
					div_start    = 1'b1;
					div_dividend = DIV_NW'({sum_q, 8'd0});
					div_divisor  = DIV_DW'(fill_q);
					state_d      = ST_M_WAIT;
				end
			end
			ST_M_WAIT: begin
				if (div_done) begin
					mean_d  = div_quo[23:0];
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					out_valid_d              = 1'b1;
					out_d.window_start_sec   = start_q;
					out_d.window_end_sec     = win_end;
					out_d.packet_count       = 13'(fill_q);
					out_d.top_count          = 13'(best_cnt_q);
					out_d.syn_minus_synack   = 14'(syn_q) - 14'(synack_q);
					out_d.fin_minus_syn      = 14'(fin_q) - 14'(syn_q);
					out_d.suspicious_count   = 13'(sus_q);
					out_d.mean_size_q8       = mean_q;
					out_d.top_avg_gap_usec   = gap_q;
					out_d.overflow           = ovf_q;
					drop_d                   = 1'b0;
					if (cur_q.kind == KIND_FLUSH) begin
						out_last_d = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						out_last_d = (n_q + 1'b1 == 7'(MAX_REPORTS)) ||
						             (21'(cur_q.rec.time_sec) <
						              21'(nxt_start) + 21'(cfg.window_len));
						n_d          = n_q + 1'b1;
						start_d      = nxt_start;
						after_skip_d = 1'b0;
						state_d      = ST_DROP_RD;
					end
				end
			end
			// drop records that fall before the new start
			ST_DROP_RD: begin
				rec_raddr = head_q;
				if (fill_q == '0) begin
					state_d = after_skip_q ? ST_APPEND : ST_CHECK;
				end else begin
					state_d = ST_DROP_CHK;
				end
			end
			ST_DROP_CHK: begin
				if (rd_rec.time_sec < start_q) begin
					head_d  = (head_inc == (AW + 1)'(RECORD_DEPTH)) ? '0 : head_inc[AW-1:0];
					fill_d  = fill_q - 1'b1;
					state_d = ST_DROP_RD;
				end else begin
					state_d = after_skip_q ? ST_APPEND : ST_CHECK;
				end
			end
			// skip the windows beyond the report limit
			ST_SK_DIV: begin
				div_start = 1'b1;
				state_d   = ST_SK_WAIT;
			end
			ST_SK_WAIT: begin
				if (div_done) begin
					k_d     = 22'(div_quo) + 22'd1;
					state_d = ST_SK_MUL;
				end
			end
			ST_SK_MUL: begin
				prod_d  = 32'(k_q) * 32'(step_eff);
				state_d = ST_SK_SET;
			end
			ST_SK_SET: begin
				start_d      = (skip_sum > 33'(START_MAX)) ? 20'(START_MAX) : skip_sum[19:0];
				after_skip_d = 1'b1;
				state_d      = ST_DROP_RD;
			end
			ST_APPEND: begin
				if (fill_q < CNT_W'(RECORD_DEPTH)) begin
					rec_we = 1'b1;
					fill_d = fill_q + 1'b1;
				end else begin
					drop_d = 1'b1;
				end
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// keep read addresses pointed at the entry the next state consumes
		if (state_q == ST_T_RD || state_q == ST_S_RD) begin
			tab_raddr = j_q[TW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= '0;
			head_q      <= '0;
			fill_q      <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			start_q     <= start_d;
			head_q      <= head_d;
			fill_q      <= fill_d;
			drop_q      <= drop_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q        <= cur_d;
		n_q          <= n_d;
		i_q          <= i_d;
		j_q          <= j_d;
		naddr_q      <= naddr_d;
		a_q          <= a_d;
		syn_q        <= syn_d;
		synack_q     <= synack_d;
		fin_q        <= fin_d;
		sus_q        <= sus_d;
		sum_q        <= sum_d;
		ovf_q        <= ovf_d;
		best_addr_q  <= best_addr_d;
		best_cnt_q   <= best_cnt_d;
		best_vld_q   <= best_vld_d;
		seen_q       <= seen_d;
		fsec_q       <= fsec_d;
		fusec_q      <= fusec_d;
		lsec_q       <= lsec_d;
		lusec_q      <= lusec_d;
		fus_q        <= fus_d;
		lus_q        <= lus_d;
		gap_q        <= gap_d;
		mean_q       <= mean_d;
		k_q          <= k_d;
		prod_q       <= prod_d;
		after_skip_q <= after_skip_d;
		out_q        <= out_d;
		out_last_q   <= out_last_d;
	end

endmodule

// File: hw/rtl/sliding_window_traffic_features.sv
// Top level: stream ports, register port, front queue and report engine.
//
// Packet records and flush commands arrive on the s_ channel (s_tuser set marks
// a flush). Reports leave on the m_ channel, m_tlast set on the last report an
// input transaction causes. Window length, step and the excluded address sit
// behind the APB port at byte addresses 0, 4 and 8; write them only while idle.
// A record that closes no window is appended after it reaches the head of the
// two-entry input queue (pop, window check, append); the engine takes the next
// item only after the append. Each report walks the record store once, looking
// up each record's address in the address table, then scans the table for the
// top address and, when one exists, walks the store again for its first and last
// time. The mean divider runs when the store is not empty and the gap divider
// when a top address exists. Windows beyond the per-item report limit are skipped
// with one division. Expired records are dropped one at a time, each read and
// checked against the new window start.
// Reset empties the record store and sets the window start to zero; no clearing
// pass runs. A stalled receiver holds one report in the output register while
// the engine finishes the next one; the input queue keeps accepting until full.
module sliding_window_traffic_features #(
	parameter int unsigned RECORD_DEPTH = 4096,
	parameter int unsigned ADDR_ENTRIES = 64,
	parameter int unsigned MAX_REPORTS  = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// src_addr, time_sec, time_usec, pkt_len, flag_class
	input  logic [swtf_pkg::IN_TDATA_W-1:0]     s_tdata,
	// operation
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// window_start_sec, window_end_sec, packet_count, top_count, syn_minus_synack,
	// fin_minus_syn, suspicious_count, mean_size_q8, top_avg_gap_usec, overflow
	output logic [swtf_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic                                m_tlast,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [3:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import swtf_pkg::*;

	cfg_t    cfg_q;
	item_t   q_item;
	logic    q_valid;
	logic    q_pop;
	report_t rep;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_len    <= 10'd65;
			cfg_q.window_step   <= 10'd10;
			cfg_q.excluded_addr <= 32'd3232235630;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_WINDOW_LEN:    cfg_q.window_len    <= pwdata[9:0];
				REG_WINDOW_STEP:   cfg_q.window_step   <= pwdata[9:0];
				REG_EXCLUDED_ADDR: cfg_q.excluded_addr <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_WINDOW_LEN:    prdata = 32'(cfg_q.window_len);
			REG_WINDOW_STEP:   prdata = 32'(cfg_q.window_step);
			REG_EXCLUDED_ADDR: prdata = cfg_q.excluded_addr;
			default:           prdata = '0;
		endcase
	end

	swtf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	swtf_back #(
		.RECORD_DEPTH (RECORD_DEPTH),
		.ADDR_ENTRIES (ADDR_ENTRIES),
		.MAX_REPORTS  (MAX_REPORTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_rep   (rep),
		.out_last  (m_tlast),
		.out_ready (m_tready)
	);

	assign m_tdata = {5'd0, rep};

endmodule

// File: hw/rtl/swtf_chk.sv
// Port-level checks for the traffic feature block, bound to the top level.
module swtf_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [swtf_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                             m_tlast
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("report dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("report changed while stalled");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[53:41] == 13'd0 |->
		m_tdata[66:54] == 13'd0 && m_tdata[131:108] == 24'd0 && m_tdata[161:132] == 30'd0)
		else $error("empty window reports nonzero features");

	a_gap_top: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[161:132] != 30'd0 |-> m_tdata[66:54] != 13'd0)
		else $error("gap reported without a top address");

endmodule

bind sliding_window_traffic_features swtf_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
